// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, cond, prop)
`define ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/core/erl_pkg.sv =====
package erl_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned WIDE_W     = 34;
    localparam int unsigned PROD_W     = 64;
    localparam int unsigned RATE_W     = 31;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);
    localparam int unsigned FRAC_W     = 16;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE   = 32'h0001_0000;

    localparam logic [DATA_W-1:0] RST_LEAD_LAG_RATIO = 32'd6554;
    localparam logic [RATE_W-1:0] RST_INV_LAG_TIME   = 31'd6554;
    localparam logic [DATA_W-1:0] RST_EXCITER_GAIN   = 32'd6553600;
    localparam logic [RATE_W-1:0] RST_INV_FIELD_TIME = 31'd1310720;
    localparam logic [DATA_W-1:0] RST_FIELD_MIN      = 32'd0;
    localparam logic [DATA_W-1:0] RST_FIELD_MAX      = 32'd327680;
    localparam logic [DATA_W-1:0] RST_VOLTAGE_REF    = 32'd65536;

    localparam logic OP_EVALUATE    = 1'b0;
    localparam logic OP_LIMIT_EVENT = 1'b1;
    localparam logic LIMIT_MAX      = 1'b0;
    localparam logic LIMIT_MIN      = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LEAD_LAG_RATIO = 3'd0,
        REG_INV_LAG_TIME   = 3'd1,
        REG_EXCITER_GAIN   = 3'd2,
        REG_INV_FIELD_TIME = 3'd3,
        REG_FIELD_MIN      = 3'd4,
        REG_FIELD_MAX      = 3'd5,
        REG_VOLTAGE_REF    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] bus_volt_real;
        logic signed [DATA_W-1:0] bus_volt_imag;
        logic signed [DATA_W-1:0] stabilizer_signal;
        logic signed [DATA_W-1:0] lead_lag_state;
        logic signed [DATA_W-1:0] field_voltage;
        logic                     limit_index;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] lead_lag_rate;
        logic signed [DATA_W-1:0] field_residual;
        logic signed [DATA_W-1:0] max_event_value;
        logic signed [DATA_W-1:0] min_event_value;
        logic                     at_max_limit;
        logic                     at_min_limit;
    } result_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    data;
    } cfg_t;

    // Saturates a 34-bit two's complement sum to 32 bits.
    function automatic logic [DATA_W-1:0] sat_wide(input logic [WIDE_W-1:0] v);
        logic [DATA_W-1:0] r;
        if ((&v[WIDE_W-1:DATA_W-1]) || (~|v[WIDE_W-1:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end else begin
            r = v[WIDE_W-1] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

    // Floors a Q32.32 product back to Q16.16 and saturates it.
    function automatic logic [DATA_W-1:0] sat_prod(input logic [PROD_W-1:0] p);
        logic [DATA_W-1:0] r;
        if ((&p[PROD_W-1:DATA_W+FRAC_W-1]) || (~|p[PROD_W-1:DATA_W+FRAC_W-1])) begin
            r = p[DATA_W+FRAC_W-1:FRAC_W];
        end else begin
            r = p[PROD_W-1] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

    function automatic logic [WIDE_W-1:0] sext(input logic [DATA_W-1:0] v);
        return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

// ===== rtl/core/erl_stream_if.sv =====
interface erl_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/erl_mul.sv =====
module erl_mul
    import erl_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic signed [PROD_W-1:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

endmodule

// ===== rtl/core/erl_sqrt.sv =====
`include "assert_macros.svh"

module erl_sqrt
    import erl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] radicand,
    output logic              done,
    output logic [DATA_W-1:0] root
);

    localparam int unsigned REM_W = DATA_W + 4;
    localparam logic [SQRT_CNT_W-1:0] LAST_STEP = SQRT_CNT_W'(SQRT_STEPS - 1);

    logic [PROD_W-1:0]     rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DATA_W-1:0]     root_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             take;

    // One result bit per step, restoring form.
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[PROD_W-1:PROD_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        take      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + SQRT_CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[PROD_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[DATA_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    `ASSERT_IMP(a_start_when_free, clk, rst_n, start, !busy_reg)

endmodule

// ===== rtl/core/exciter_residual_with_limits.sv =====
// Residual evaluator for a simplified excitation system with field limits, Q16.16 throughout.
// Items and results are transferred on valid/ready channels, and configuration registers are
// written on a channel of their own that is always ready; write them only while the block
// is idle. An evaluate item squares and sums the bus voltage parts, runs the iterative
// square root (one result bit per cycle), then forms the error and the ratio, one minus ratio,
// gain, lag time and field time products through the single shared 32 by 32 multiplier and
// its saturating adders. A limit-event item toggles its flag on transfer and goes straight to
// the done state. The block takes no new item until the current result has been loaded into
// the output register, which may then wait for the consumer while the next item is taken.
`include "assert_macros.svh"

module exciter_residual_with_limits
    import erl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    erl_stream_if.sink   item,
    erl_stream_if.source result,
    erl_stream_if.sink   cfg
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_SQ_D   = 12'b0000_0000_0010,
        ST_SQ_Q   = 12'b0000_0000_0100,
        ST_SQ_SUM = 12'b0000_0000_1000,
        ST_SQRT   = 12'b0000_0001_0000,
        ST_ERR    = 12'b0000_0010_0000,
        ST_M_RE   = 12'b0000_0100_0000,
        ST_M_OE   = 12'b0000_1000_0000,
        ST_M_KY   = 12'b0001_0000_0000,
        ST_M_TL   = 12'b0010_0000_0000,
        ST_M_TF   = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DATA_W-1:0] ratio_reg;
    logic [RATE_W-1:0] inv_lag_reg;
    logic [DATA_W-1:0] gain_reg;
    logic [RATE_W-1:0] inv_field_reg;
    logic [DATA_W-1:0] fmin_reg;
    logic [DATA_W-1:0] fmax_reg;
    logic [DATA_W-1:0] vref_reg;

    logic max_flag_reg;
    logic min_flag_reg;
    logic event_reg;

    item_t             item_reg;
    logic [PROD_W-1:0] sumsq_reg;
    logic [DATA_W-1:0] err_reg;
    logic [DATA_W-1:0] onem_reg;
    logic [DATA_W-1:0] y1_reg;
    logic [DATA_W-1:0] tmp_reg;
    logic [DATA_W-1:0] rate_reg;

    result_t result_reg;
    logic    result_valid_reg;

    logic                     item_accept;
    logic                     item_event;
    logic                     out_load;
    logic                     mul_en;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [DATA_W-1:0]        prod_q;
    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [DATA_W-1:0]        sqrt_root;
    logic [DATA_W-1:0]        vm;
    logic [DATA_W-1:0]        drive;
    result_t                  result_next;

    assign cfg.ready   = 1'b1;
    assign item.ready  = (state_reg == ST_IDLE);
    assign item_accept = item.valid && item.ready;
    assign item_event  = (item.payload.operation == OP_LIMIT_EVENT);
    assign out_load    = (state_reg == ST_DONE) && (!result_valid_reg || result.ready);
    assign sqrt_start  = (state_reg == ST_SQ_SUM);
    assign prod_q      = sat_prod(prod);
    assign vm          = sqrt_root[DATA_W-1] ? SAT_MAX : sqrt_root;
    assign drive       = prod_q;

    erl_mul u_mul (
        .clk      (clk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    erl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sumsq_reg + $unsigned(prod)),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_SQ_D:
            begin
                mul_a = item_reg.bus_volt_real;
                mul_b = item_reg.bus_volt_real;
            end
            ST_SQ_Q:
            begin
                mul_a = item_reg.bus_volt_imag;
                mul_b = item_reg.bus_volt_imag;
            end
            ST_M_RE:
            begin
                mul_a = $signed(ratio_reg);
                mul_b = $signed(err_reg);
            end
            ST_M_OE:
            begin
                mul_a = $signed(onem_reg);
                mul_b = $signed(err_reg);
            end
            ST_M_KY:
            begin
                mul_a = $signed(gain_reg);
                mul_b = $signed(y1_reg);
            end
            ST_M_TL:
            begin
                mul_a = $signed(tmp_reg);
                mul_b = $signed({1'b0, inv_lag_reg});
            end
            ST_M_TF:
            begin
                mul_a = $signed(tmp_reg);
                mul_b = $signed({1'b0, inv_field_reg});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = item_event ? ST_DONE : ST_SQ_D;
                end
            end
            ST_SQ_D:   state_next = ST_SQ_Q;
            ST_SQ_Q:   state_next = ST_SQ_SUM;
            ST_SQ_SUM: state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:    state_next = ST_M_RE;
            ST_M_RE:   state_next = ST_M_OE;
            ST_M_OE:   state_next = ST_M_KY;
            ST_M_KY:   state_next = ST_M_TL;
            ST_M_TL:   state_next = ST_M_TF;
            ST_M_TF:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // While a flag is held, the residual clamps the field to that limit; max takes precedence.
    always_comb
    begin
        result_next.at_max_limit = max_flag_reg;
        result_next.at_min_limit = min_flag_reg;
        if (event_reg)
        begin
            result_next.lead_lag_rate   = '0;
            result_next.field_residual  = '0;
            result_next.max_event_value = '0;
            result_next.min_event_value = '0;
        end
        else
        begin
            result_next.lead_lag_rate = rate_reg;
            if (max_flag_reg)
            begin
                result_next.field_residual =
                    sat_wide(sext(item_reg.field_voltage) - sext(fmax_reg));
            end
            else if (min_flag_reg)
            begin
                result_next.field_residual =
                    sat_wide(sext(item_reg.field_voltage) - sext(fmin_reg));
            end
            else
            begin
                result_next.field_residual = drive;
            end
            result_next.max_event_value = max_flag_reg ? drive :
                sat_wide(sext(fmax_reg) - sext(item_reg.field_voltage));
            result_next.min_event_value = min_flag_reg ? drive :
                sat_wide(sext(fmin_reg) - sext(item_reg.field_voltage));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            max_flag_reg     <= 1'b0;
            min_flag_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            ratio_reg        <= RST_LEAD_LAG_RATIO;
            inv_lag_reg      <= RST_INV_LAG_TIME;
            gain_reg         <= RST_EXCITER_GAIN;
            inv_field_reg    <= RST_INV_FIELD_TIME;
            fmin_reg         <= RST_FIELD_MIN;
            fmax_reg         <= RST_FIELD_MAX;
            vref_reg         <= RST_VOLTAGE_REF;
        end
        else
        begin
            state_reg <= state_next;
            if (item_accept && item_event)
            begin
                if (item.payload.limit_index == LIMIT_MAX)
                begin
                    max_flag_reg <= !max_flag_reg;
                end
                else
                begin
                    min_flag_reg <= !min_flag_reg;
                end
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.payload.index)
                    REG_LEAD_LAG_RATIO: ratio_reg     <= cfg.payload.data;
                    REG_INV_LAG_TIME:   inv_lag_reg   <= cfg.payload.data[RATE_W-1:0];
                    REG_EXCITER_GAIN:   gain_reg      <= cfg.payload.data;
                    REG_INV_FIELD_TIME: inv_field_reg <= cfg.payload.data[RATE_W-1:0];
                    REG_FIELD_MIN:      fmin_reg      <= cfg.payload.data;
                    REG_FIELD_MAX:      fmax_reg      <= cfg.payload.data;
                    REG_VOLTAGE_REF:    vref_reg      <= cfg.payload.data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg  <= item.payload;
            event_reg <= item_event;
        end
        if (state_reg == ST_SQ_Q)
        begin
            sumsq_reg <= $unsigned(prod);
        end
        if (state_reg == ST_ERR)
        begin
            err_reg  <= sat_wide(sext(vref_reg) + sext(item_reg.stabilizer_signal)
                                 - {{(WIDE_W-DATA_W){1'b0}}, vm});
            onem_reg <= sat_wide(sext(Q_ONE) - sext(ratio_reg));
        end
        if (state_reg == ST_M_OE)
        begin
            y1_reg <= sat_wide(sext(item_reg.lead_lag_state) + sext(prod_q));
        end
        if (state_reg == ST_M_KY)
        begin
            tmp_reg <= sat_wide(sext(prod_q) - sext(item_reg.lead_lag_state));
        end
        if (state_reg == ST_M_TL)
        begin
            tmp_reg <= sat_wide(sext(prod_q) - sext(item_reg.field_voltage));
        end
        if (state_reg == ST_M_TF)
        begin
            rate_reg <= prod_q;
        end
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

    `ASSERT_IMP(a_sqrt_done_in_wait, clk, rst_n, sqrt_done, state_reg == ST_SQRT)
    `ASSERT_NXT(a_max_toggle, clk, rst_n, item_accept && item_event && item.payload.limit_index == LIMIT_MAX, max_flag_reg != $past(max_flag_reg))
    `ASSERT_NXT(a_flags_hold, clk, rst_n, !(item_accept && item_event), $stable(max_flag_reg) && $stable(min_flag_reg))
    `ASSERT_NXT(a_load_shows, clk, rst_n, out_load, result.valid)

endmodule
